// ===== rtl/core/otp_hmac_sha1_validator_assert.svh =====
// Assertion macros shared by the validator RTL
`ifndef OTP_HMAC_SHA1_VALIDATOR_ASSERT_SVH
`define OTP_HMAC_SHA1_VALIDATOR_ASSERT_SVH
// same-cycle implication, sampled on clk, off during rst
`define OTPV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define OTPV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/otpv_pkg.sv =====
// Types, constants and SHA-1 helper functions for the OTP validator
package otpv_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] sha_state_t;
  typedef word_t [15:0] sha_win_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_RUN
  } ks_state_t;

  localparam logic [1:0] CFG_KEY_HIGH  = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW   = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP = 2'd2;

  localparam logic [7:0]  TS_RESET   = 8'd30;
  localparam logic [7:0]  IPAD       = 8'h36;
  localparam logic [7:0]  OPAD       = 8'h5C;
  localparam word_t       PAD_WORD   = 32'h8000_0000;
  localparam word_t       LEN_INNER  = 32'd576;
  localparam word_t       LEN_OUTER  = 32'd672;
  localparam logic [19:0] CODE_MOD   = 20'd1000000;
  localparam logic [12:0] CODE_RECIP = 13'd4294;
  localparam logic [6:0]  LAST_ROUND = 7'd79;

  function automatic sha_state_t sha_iv();
    sha_state_t s;
    s[0] = 32'h6745_2301;
    s[1] = 32'hEFCD_AB89;
    s[2] = 32'h98BA_DCFE;
    s[3] = 32'h1032_5476;
    s[4] = 32'hC3D2_E1F0;
    return s;
  endfunction

  function automatic sha_state_t sha_add(sha_state_t a, sha_state_t b);
    sha_state_t r;
    for (int i = 0; i < 5; i++) begin
      r[i] = a[i] + b[i];
    end
    return r;
  endfunction

  function automatic sha_state_t sha1_round(sha_state_t s, word_t w, logic [6:0] t);
    sha_state_t r;
    word_t f;
    word_t k;
    priority if (t < 7'd20) begin
      f = (s[1] & s[2]) | (~s[1] & s[3]);
      k = 32'h5A82_7999;
    end else if (t < 7'd40) begin
      f = s[1] ^ s[2] ^ s[3];
      k = 32'h6ED9_EBA1;
    end else if (t < 7'd60) begin
      f = (s[1] & s[2]) | (s[1] & s[3]) | (s[2] & s[3]);
      k = 32'h8F1B_BCDC;
    end else begin
      f = s[1] ^ s[2] ^ s[3];
      k = 32'hCA62_C1D6;
    end
    r[0] = {s[0][26:0], s[0][31:27]} + f + s[4] + k + w;
    r[1] = s[0];
    r[2] = {s[1][1:0], s[1][31:2]};
    r[3] = s[2];
    r[4] = s[3];
    return r;
  endfunction

  function automatic sha_win_t win_next(sha_win_t w);
    sha_win_t r;
    word_t x;
    x = w[13] ^ w[8] ^ w[2] ^ w[0];
    r[14:0] = w[15:1];
    r[15] = {x[30:0], x[31]};
    return r;
  endfunction

  function automatic sha_win_t key_block(logic [15:0] kh, logic [63:0] kl, logic [7:0] pad);
    sha_win_t r;
    for (int i = 0; i < 16; i++) begin
      r[i] = {4{pad}};
    end
    r[0] = {kh, kl[63:48]} ^ {4{pad}};
    r[1] = kl[47:16] ^ {4{pad}};
    r[2] = {kl[15:0], 16'h0000} ^ {4{pad}};
    return r;
  endfunction

  function automatic sha_win_t tail_inner(logic [63:0] cnt);
    sha_win_t r;
    r = '0;
    r[0] = cnt[63:32];
    r[1] = cnt[31:0];
    r[2] = PAD_WORD;
    r[15] = LEN_INNER;
    return r;
  endfunction

  function automatic sha_win_t tail_outer(sha_state_t d);
    sha_win_t r;
    r = '0;
    for (int i = 0; i < 5; i++) begin
      r[i] = d[i];
    end
    r[5] = PAD_WORD;
    r[15] = LEN_OUTER;
    return r;
  endfunction

endpackage

// ===== rtl/core/otpv_keysched.sv =====
// Iterative hasher of the padded key blocks, inner and outer chain values
module otpv_keysched (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load_req,
  input  logic [15:0]           key_high,
  input  logic [63:0]           key_low,
  output logic                  busy,
  output otpv_pkg::sha_state_t  ihash,
  output otpv_pkg::sha_state_t  ohash
);
  import otpv_pkg::*;

  ks_state_t  state;
  ks_state_t  state_next;
  logic [6:0] cnt;
  sha_state_t ist;
  sha_state_t ost;
  sha_win_t   iwin;
  sha_win_t   owin;
  sha_state_t ist_next;
  sha_state_t ost_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ist_next = sha1_round(ist, iwin[0], cnt);
    ost_next = sha1_round(ost, owin[0], cnt);
    busy = (state != KS_IDLE);
    if (load_req) begin
      state_next = KS_LOAD;
    end else begin
      unique case (state)
        KS_LOAD: state_next = KS_RUN;
        KS_RUN:  state_next = (cnt == LAST_ROUND) ? KS_IDLE : KS_RUN;
        default: state_next = KS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == KS_LOAD) begin
      cnt <= '0;
      ist <= sha_iv();
      ost <= sha_iv();
      iwin <= key_block(key_high, key_low, IPAD);
      owin <= key_block(key_high, key_low, OPAD);
    end else if (state == KS_RUN) begin
      cnt <= cnt + 7'd1;
      ist <= ist_next;
      ost <= ost_next;
      iwin <= win_next(iwin);
      owin <= win_next(owin);
      if (cnt == LAST_ROUND) begin
        ihash <= sha_add(sha_iv(), ist_next);
        ohash <= sha_add(sha_iv(), ost_next);
      end
    end
  end

endmodule

// ===== rtl/core/otpv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module otpv_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] in_num,
  input  logic [7:0]  in_div,
  input  logic [19:0] in_tag,
  output logic        out_valid,
  output logic [63:0] out_quot,
  output logic [19:0] out_tag
);
  import otpv_pkg::*;

  logic        vld [64];
  logic [63:0] num [64];
  logic [7:0]  rem [64];
  logic [7:0]  dv  [64];
  logic [19:0] tag [64];

  for (genvar i = 0; i < 64; i++) begin : g_stage
    logic        v_in;
    logic [63:0] n_in;
    logic [7:0]  r_in;
    logic [7:0]  d_in;
    logic [19:0] t_in;
    logic [8:0]  r9;
    logic        ge;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = in_num;
      assign r_in = '0;
      assign d_in = in_div;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign n_in = num[i-1];
      assign r_in = rem[i-1];
      assign d_in = dv[i-1];
      assign t_in = tag[i-1];
    end

    assign r9 = {r_in, n_in[63]};
    assign ge = (r9 >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
      num[i] <= {n_in[62:0], ge};
      rem[i] <= ge ? 8'(r9 - {1'b0, d_in}) : r9[7:0];
      dv[i] <= d_in;
      tag[i] <= t_in;
    end
  end

  assign out_valid = vld[63];
  assign out_quot = num[63];
  assign out_tag = tag[63];

endmodule

// ===== rtl/core/otpv_sha1_pipe.sv =====
// Unrolled SHA-1 compression, one round per stage, chain value added at the end
module otpv_sha1_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  otpv_pkg::sha_win_t    in_win,
  input  logic [19:0]           in_tag,
  input  otpv_pkg::sha_state_t  chain,
  output logic                  out_valid,
  output otpv_pkg::sha_state_t  out_digest,
  output logic [19:0]           out_tag
);
  import otpv_pkg::*;

  logic       vld [80];
  sha_state_t st  [80];
  sha_win_t   win [80];
  logic [19:0] tag [80];

  for (genvar i = 0; i < 80; i++) begin : g_round
    logic       v_in;
    sha_state_t s_in;
    sha_win_t   w_in;
    logic [19:0] t_in;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = chain;
      assign w_in = in_win;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign s_in = st[i-1];
      assign w_in = win[i-1];
      assign t_in = tag[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
      st[i] <= sha1_round(s_in, w_in[0], 7'(i));
      win[i] <= win_next(w_in);
      tag[i] <= t_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[79];
    end
    out_digest <= sha_add(chain, st[79]);
    out_tag <= tag[79];
  end

endmodule

// ===== rtl/core/otpv_trunc_mod.sv =====
// Dynamic truncation, reduction modulo one million and code compare
module otpv_trunc_mod (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  otpv_pkg::sha_state_t  digest,
  input  logic [19:0]           cand,
  output logic                  done,
  output logic                  valid_res,
  output logic [19:0]           computed_code
);
  import otpv_pkg::*;

  logic [159:0] flat;
  logic [31:0]  sel;
  logic         va, vb, vc;
  logic [30:0]  bin_a, bin_b, bin_c;
  logic [19:0]  cand_a, cand_b, cand_c;
  logic [43:0]  prod_b;
  logic [31:0]  m_c;
  logic [31:0]  r_d;
  logic [31:0]  code_d;

  assign flat = {digest[0], digest[1], digest[2], digest[3], digest[4]};

  always_comb begin
    sel = '0;
    for (int j = 0; j < 16; j++) begin
      if (flat[3:0] == 4'(j)) begin
        sel = flat[159 - 8*j -: 32];
      end
    end
    r_d = {1'b0, bin_c} - m_c;
    code_d = (r_d >= 32'(CODE_MOD)) ? r_d - 32'(CODE_MOD) : r_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      done <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      done <= vc;
    end
    bin_a <= sel[30:0];
    cand_a <= cand;
    prod_b <= 44'(bin_a) * 44'(CODE_RECIP);
    bin_b <= bin_a;
    cand_b <= cand_a;
    m_c <= 32'(prod_b[43:32]) * 32'(CODE_MOD);
    bin_c <= bin_b;
    cand_c <= cand_b;
    computed_code <= code_d[19:0];
    valid_res <= (cand_c == code_d[19:0]);
  end

endmodule

// ===== rtl/core/otp_hmac_sha1_validator.sv =====
// HOTP/TOTP six-digit code checker, HMAC-SHA1 with dynamic truncation
// Throughput: one request per cycle while busy is low; done cannot be held off.
// Divider, two 80-round SHA-1 pipelines and a four-stage reduction set the depth.
// busy is high after reset and after each key write while the
// iterative key hasher forms the inner and outer chain values.
module otp_hmac_sha1_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [63:0] counter_or_time,
  input  logic [19:0] candidate_code,
  output logic        done,
  output logic        valid_res,
  output logic [19:0] computed_code
);
  import otpv_pkg::*;

  `include "otp_hmac_sha1_validator_assert.svh"

  localparam int LATENCY = 230;

  logic [15:0] key_high;
  logic [63:0] key_low;
  logic [7:0]  time_step;
  logic        key_wr;
  logic        accept;
  logic [7:0]  divisor;
  sha_state_t  ihash;
  sha_state_t  ohash;
  logic        div_valid;
  logic [63:0] div_quot;
  logic [19:0] div_tag;
  logic        in_valid_h;
  sha_state_t  in_digest;
  logic [19:0] in_tag_h;
  logic        out_valid_h;
  sha_state_t  out_digest;
  logic [19:0] out_tag_h;

  assign key_wr = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
  assign accept = start && !busy;
  assign divisor = !op ? 8'd1 : ((time_step == 8'd0) ? 8'd1 : time_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      time_step <= TS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH:  key_high <= cfg_data[15:0];
        CFG_KEY_LOW:   key_low <= cfg_data;
        CFG_TIME_STEP: time_step <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  otpv_keysched u_keysched (
    .clk      (clk),
    .rst      (rst),
    .load_req (key_wr),
    .key_high (key_high),
    .key_low  (key_low),
    .busy     (busy),
    .ihash    (ihash),
    .ohash    (ohash)
  );

  otpv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_num    (counter_or_time),
    .in_div    (divisor),
    .in_tag    (candidate_code),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_tag   (div_tag)
  );

  otpv_sha1_pipe u_inner (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_win     (tail_inner(div_quot)),
    .in_tag     (div_tag),
    .chain      (ihash),
    .out_valid  (in_valid_h),
    .out_digest (in_digest),
    .out_tag    (in_tag_h)
  );

  otpv_sha1_pipe u_outer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid_h),
    .in_win     (tail_outer(in_digest)),
    .in_tag     (in_tag_h),
    .chain      (ohash),
    .out_valid  (out_valid_h),
    .out_digest (out_digest),
    .out_tag    (out_tag_h)
  );

  otpv_trunc_mod u_trunc (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (out_valid_h),
    .digest        (out_digest),
    .cand          (out_tag_h),
    .done          (done),
    .valid_res     (valid_res),
    .computed_code (computed_code)
  );

  `OTPV_ASSERT_IMP(a_latency, done, $past(start && !busy, LATENCY), "done without request")
  `OTPV_ASSERT_IMP(a_code_range, done, computed_code < CODE_MOD, "code out of range")
  `OTPV_ASSERT_NXT(a_key_busy, key_wr, busy, "key write did not rehash")

endmodule
